/* hw/rtl/ctl_pkg.sv */
// ----------------------------------------------------------------------------
// ctl_pkg: shared constants and types of the command token lexer
// Token kinds, register indices, character codes and default settings.
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int HASH_TABLE_SIZE_DEF = 4096;
    localparam int MAX_TOKEN_LEN_DEF   = 1023;
    localparam int HASH_W              = 32;
    localparam int NUM_W               = 64;
    localparam int LEN_W               = 10;

    localparam logic [15:0] HASH_MULT_RST = 16'd1024;
    localparam logic [15:0] HASH_DIV_RST  = 16'd64;

    localparam logic [0:0] CFG_HASH_MULT = 1'd0;
    localparam logic [0:0] CFG_HASH_DIV  = 1'd1;

    typedef enum logic [3:0] {
        KIND_END      = 4'd0,
        KIND_INT      = 4'd1,
        KIND_ID       = 4'd2,
        KIND_VER      = 4'd3,
        KIND_BAD_NUM  = 4'd4,
        KIND_BAD_ID   = 4'd5,
        KIND_BAD_CHAR = 4'd6,
        KIND_UPPER_V  = 4'd7,
        KIND_OVF      = 4'd8
    } kind_t;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

endpackage

/* hw/rtl/command_token_lexer.sv */
// ----------------------------------------------------------------------------
// command_token_lexer: character stream lexer for command text
// Skips blanks, builds integer and identifier tokens with a keyword hash.
// ----------------------------------------------------------------------------
// One character word per s_ handshake. A blank, a digit or a dropped
// character that ends no token passes through the accept and finish phases
// only. A letter or identifier character runs the hash step through a
// bit-serial unit, a shift-add multiply over the multiplier bits followed by
// a restoring divide. A terminator that ends a token, and any semicolon,
// yields one or two result words on m_ through one output register, each
// word waiting until the output register has drained.
// s_ready stays low until the last word of a character is loaded; the next
// character waits while a word is still held. Integer digits update a
// 64-bit accumulator with one shift-add (x8 + x2 + d) per digit.
// Configuration writes are taken at any time but must only be issued while
// the lexer is idle.
module command_token_lexer #(
    parameter int HASH_TABLE_SIZE = ctl_pkg::HASH_TABLE_SIZE_DEF,
    parameter int MAX_TOKEN_LEN   = ctl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [63:0] m_int_value,
    output logic [11:0] m_key_hash,
    output logic [9:0]  m_token_len,
    output logic        m_last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ctl_pkg::*;

    localparam int KEY_W = $clog2(HASH_TABLE_SIZE);

    typedef enum logic [1:0] {M_IDLE, M_NUM, M_ID, M_DROP} mode_t;
    typedef enum logic [2:0] {P_ACC, P_HASH, P_WAIT, P_OUT1, P_OUT2, P_FIN}
        ph_t;

    mode_t              mode_reg;
    ph_t                ph_reg;
    logic [15:0]        mult_reg, div_reg;
    logic [7:0]         ch_reg;
    logic [NUM_W-1:0]   num_reg;
    logic               ovf_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [LEN_W-1:0]   cnt_reg;
    logic               up_reg, ver_reg;
    logic               busy_reg;
    // pending second word
    logic               two_reg;
    logic               mv_reg;
    logic [3:0]         kind_reg;
    logic [63:0]        val_reg;
    logic [11:0]        key_reg;
    logic [9:0]         len_reg;
    logic               last_reg;

    logic               hs_start, hs_busy, hs_done;
    logic [HASH_W-1:0]  hs_out;
    logic               out_free;
    logic               word_load;

    // character classes
    logic c_blank, c_semi, c_term, c_digit, c_up, c_lo, c_ver, c_idch;
    assign c_blank = ch_reg == CH_SPACE || ch_reg == CH_TAB || ch_reg == CH_LF;
    assign c_semi  = ch_reg == CH_SEMI;
    assign c_term  = c_blank || c_semi;
    assign c_digit = ch_reg >= 8'h30 && ch_reg <= 8'h39;
    assign c_up    = ch_reg >= 8'h41 && ch_reg <= 8'h5A;
    assign c_lo    = ch_reg >= 8'h61 && ch_reg <= 8'h7A;
    assign c_ver   = ch_reg == CH_DASH || ch_reg == CH_DOT;
    assign c_idch  = c_ver || ch_reg == CH_UNDER || c_up || c_lo || c_digit;

    logic [7:0] ch_up;
    assign ch_up = c_lo ? ch_reg - 8'h20 : ch_reg;

    // number step: overflow test and x10 + d in one narrow-enough add
    logic [67:0] num_x10;
    logic [3:0]  dig;
    assign dig     = ch_reg[3:0];
    assign num_x10 = {1'b0, num_reg, 3'b0} + {3'b0, num_reg, 1'b0} + {64'd0, dig};

    logic [LEN_W-1:0] cnt_inc;
    assign cnt_inc = (cnt_reg < LEN_W'(MAX_TOKEN_LEN)) ? cnt_reg + 1'b1 : cnt_reg;

    // finalize: shifts, adds and an xor only
    logic [HASH_W-1:0] f1, f2, f3;
    assign f1 = hash_reg + (hash_reg << 3);
    assign f2 = f1 ^ (f1 >> 11);
    assign f3 = f2 + (f2 << 5);
    logic [11:0] key_fin;
    assign key_fin = 12'(f3[KEY_W-1:0]);

    assign hs_start = (ph_reg == P_HASH);
    assign hs_busy  = (ph_reg == P_WAIT);

    // payload registers double as staging, so a new word waits for the old
    assign out_free  = !mv_reg || m_ready;
    assign word_load = busy_reg && (ph_reg == P_OUT1 || ph_reg == P_OUT2) && out_free;

    ctl_hash_step u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hs_start),
        .hash_in  (hash_reg),
        .char_up  (ch_up),
        .mult     (mult_reg),
        .div      (div_reg),
        .done     (hs_done),
        .hash_out (hs_out)
    );

    assign s_ready   = ~busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            ph_reg   <= P_ACC;
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
            two_reg  <= 1'b0;
            mult_reg <= HASH_MULT_RST;
            div_reg  <= HASH_DIV_RST;
            num_reg  <= '0;
            ovf_reg  <= 1'b0;
            hash_reg <= '0;
            cnt_reg  <= '0;
            up_reg   <= 1'b0;
            ver_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_HASH_MULT) mult_reg <= cfg_data;
                else div_reg <= cfg_data;
            end
            if (word_load) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;

            if (!busy_reg) begin
                if (s_valid) begin
                    ch_reg   <= s_char_in;
                    busy_reg <= 1'b1;
                    ph_reg   <= P_ACC;
                end
            end else begin
                unique case (ph_reg)
                    P_ACC: begin
                        if (out_free) begin
                            ph_reg   <= P_FIN;
                            two_reg  <= 1'b0;
                            kind_reg <= KIND_END;
                            val_reg  <= '0;
                            key_reg  <= '0;
                            len_reg  <= '0;
                            unique case (mode_reg)
                                M_IDLE: begin
                                    if (c_semi) begin
                                        ph_reg <= P_OUT1;
                                    end else if (c_digit) begin
                                        num_reg  <= {60'd0, dig};
                                        ovf_reg  <= 1'b0;
                                        hash_reg <= '0;
                                        cnt_reg  <= LEN_W'(1);
                                        up_reg   <= 1'b0;
                                        ver_reg  <= 1'b0;
                                        mode_reg <= M_NUM;
                                    end else if (c_up || c_lo) begin
                                        num_reg  <= '0;
                                        ovf_reg  <= 1'b0;
                                        hash_reg <= '0;
                                        cnt_reg  <= LEN_W'(1);
                                        up_reg   <= c_up;
                                        ver_reg  <= 1'b0;
                                        mode_reg <= M_ID;
                                        ph_reg   <= P_HASH;
                                    end else if (!c_blank) begin
                                        kind_reg <= KIND_BAD_CHAR;
                                        len_reg  <= 10'd1;
                                        mode_reg <= M_DROP;
                                        ph_reg   <= P_OUT1;
                                    end
                                end
                                M_NUM: begin
                                    if (c_digit) begin
                                        if (num_x10[67:64] != 4'd0) ovf_reg <= 1'b1;
                                        else num_reg <= num_x10[63:0];
                                        cnt_reg <= cnt_inc;
                                    end else begin
                                        len_reg <= 10'(cnt_reg);
                                        ph_reg  <= P_OUT1;
                                        if (!c_term) begin
                                            kind_reg <= KIND_BAD_NUM;
                                            mode_reg <= M_DROP;
                                        end else if (ovf_reg) begin
                                            kind_reg <= KIND_OVF;
                                            mode_reg <= M_DROP;
                                        end else begin
                                            kind_reg <= KIND_INT;
                                            val_reg  <= num_reg;
                                            mode_reg <= M_IDLE;
                                        end
                                        if (c_semi) begin
                                            two_reg  <= 1'b1;
                                            mode_reg <= M_IDLE;
                                        end
                                    end
                                end
                                M_ID: begin
                                    if (c_ver) ver_reg <= 1'b1;
                                    if (c_up) up_reg <= 1'b1;
                                    if (c_idch) begin
                                        cnt_reg <= cnt_inc;
                                        ph_reg  <= P_HASH;
                                    end else begin
                                        len_reg <= 10'(cnt_reg);
                                        ph_reg  <= P_OUT1;
                                        if (!c_term) begin
                                            kind_reg <= KIND_BAD_ID;
                                            mode_reg <= M_DROP;
                                        end else if (up_reg && ver_reg) begin
                                            kind_reg <= KIND_UPPER_V;
                                            mode_reg <= M_DROP;
                                        end else begin
                                            kind_reg <= ver_reg ? KIND_VER : KIND_ID;
                                            key_reg  <= key_fin;
                                            mode_reg <= M_IDLE;
                                        end
                                        if (c_semi) begin
                                            two_reg  <= 1'b1;
                                            mode_reg <= M_IDLE;
                                        end
                                    end
                                end
                                default: begin
                                    if (c_semi) begin
                                        mode_reg <= M_IDLE;
                                        ph_reg   <= P_OUT1;
                                    end
                                end
                            endcase
                        end
                    end
                    P_HASH: ph_reg <= P_WAIT;
                    P_WAIT: begin
                        if (hs_done) begin
                            hash_reg <= hs_out;
                            ph_reg   <= P_FIN;
                        end
                    end
                    P_OUT1: begin
                        if (word_load) begin
                            last_reg <= ~two_reg;
                            ph_reg   <= two_reg ? P_OUT2 : P_FIN;
                        end
                    end
                    P_OUT2: begin
                        if (word_load) begin
                            kind_reg <= KIND_END;
                            val_reg  <= '0;
                            key_reg  <= '0;
                            len_reg  <= '0;
                            last_reg <= 1'b1;
                            ph_reg   <= P_FIN;
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        ph_reg   <= P_ACC;
                    end
                endcase
            end
        end
    end

    assign m_valid       = mv_reg;
    assign m_token_kind  = kind_reg;
    assign m_int_value   = val_reg;
    assign m_key_hash    = key_reg;
    assign m_token_len   = len_reg;
    assign m_last_of_run = last_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready) else $error("input taken while busy");
    a_hash_in_id: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_busy |-> mode_reg == M_ID) else $error("hash outside identifier");
    a_second_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == P_OUT2) |-> two_reg) else $error("stray end word");
`endif

endmodule

/* hw/rtl/ctl_hash_step.sv */
// ----------------------------------------------------------------------------
// ctl_hash_step: one keyword hash step, bit serial
// h += c; h += h*mult (one bit of mult per cycle); h ^= h/div (restoring
// divide, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module ctl_hash_step (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ctl_pkg::HASH_W-1:0]   hash_in,
    input  logic [7:0]                   char_up,
    input  logic [15:0]                  mult,
    input  logic [15:0]                  div,
    output logic                         done,
    output logic [ctl_pkg::HASH_W-1:0]   hash_out
);
    import ctl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} st_t;

    st_t               st_reg;
    logic [4:0]        cnt_reg;
    logic [HASH_W-1:0] h_reg;      // multiplicand shifting up, then h for the xor
    logic [HASH_W-1:0] acc_reg;    // product
    logic [15:0]       mul_reg;
    logic [HASH_W-1:0] dvd_reg;    // dividend shifting out, quotient in
    logic [15:0]       rem_reg;
    logic              done_reg;

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic [HASH_W-1:0] mul_sum;

    assign rem_sh  = {rem_reg, dvd_reg[HASH_W-1]};
    assign rem_sub = rem_sh - {1'b0, div};
    // shifted multiplicand, added when that multiplier bit is set
    assign mul_sum = acc_reg + (mul_reg[0] ? h_reg : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (st_reg == S_DIV) && (cnt_reg == 5'd31);
            unique case (st_reg)
                S_IDLE: begin
                    if (start) begin
                        h_reg   <= hash_in + {24'd0, char_up};
                        acc_reg <= hash_in + {24'd0, char_up};
                        mul_reg <= mult;
                        cnt_reg <= '0;
                        st_reg  <= S_MUL;
                    end
                end
                S_MUL: begin
                    acc_reg <= mul_sum;
                    mul_reg <= mul_reg >> 1;
                    if (cnt_reg == 5'd15) begin
                        dvd_reg <= mul_sum;
                        h_reg   <= mul_sum;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        st_reg  <= S_DIV;
                    end else begin
                        h_reg   <= h_reg << 1;
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIV: begin
                    // zero divisor: every quotient bit is set
                    if (div == 16'd0 || !rem_sub[16]) begin
                        rem_reg <= rem_sub[15:0];
                        dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[15:0];
                        dvd_reg <= {dvd_reg[HASH_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign hash_out = h_reg ^ dvd_reg;

endmodule

/* dv/command_token_lexer_check.sv */
// ----------------------------------------------------------------------------
// command_token_lexer_check: result checker for the command token lexer
// Watches the character, result and register channels, computes the tokens
// each accepted character produces and compares them in order.
// ----------------------------------------------------------------------------
module command_token_lexer_check
    import ctl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_token_kind,
    input  logic [63:0] m_int_value,
    input  logic [11:0] m_key_hash,
    input  logic [9:0]  m_token_len,
    input  logic        m_last_of_run,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          tokens_pending
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [11:0] key;
        logic [9:0]  len;
        logic        last;
    } token_t;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_ID, SCAN_DROP} scan_t;

    token_t      token_q[$];
    logic [15:0] mult_r, div_r;
    scan_t       scan;
    logic [63:0] accum;
    logic        ovf, upper_seen, ver_seen;
    logic [31:0] hash;
    logic [9:0]  count;

    assign tokens_pending = token_q.size();

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic hash_step(logic [7:0] c);
        logic [31:0] h, q;
        h = hash;
        if (c >= "a" && c <= "z") c = c - 8'd32;
        h = h + {24'd0, c};
        h = h + h * {16'd0, mult_r};
        q = (div_r == 16'd0) ? 32'hFFFF_FFFF : h / {16'd0, div_r};
        hash = h ^ q;
    endtask

    function automatic logic [11:0] hash_key(logic [31:0] h);
        h = h + h * 32'd8;
        h = h ^ (h / 32'd2048);
        h = h + h * 32'd32;
        return h[11:0];
    endfunction

    task automatic bump();
        if (count < 10'd1023) count = count + 10'd1;
    endtask

    task automatic push_token(logic [3:0] k, logic [63:0] v, logic [11:0] key,
                              logic [9:0] len);
        token_t t;
        t = '{kind: k, value: v, key: key, len: len, last: 1'b0};
        token_q.push_back(t);
    endtask

    task automatic restart();
        accum = '0; ovf = 0; hash = '0; count = '0; upper_seen = 0; ver_seen = 0;
    endtask

    // Tokens for one character; marks the last one it produces.
    task automatic lex_char(logic [7:0] c);
        logic semi, blank, term, err;
        int n;
        logic [63:0] d;
        semi  = (c == CH_SEMI);
        blank = (c == CH_SPACE || c == CH_TAB || c == CH_LF);
        term  = semi || blank;
        err   = 0;
        n     = token_q.size();
        case (scan)
            SCAN_IDLE: begin
                if (semi) push_token(KIND_END, 0, 0, 0);
                else if (!blank) begin
                    restart();
                    if (is_num(c)) begin
                        accum = {56'd0, c - 8'h30}; bump(); scan = SCAN_NUM;
                    end else if (is_letter(c)) begin
                        upper_seen = (c >= "A" && c <= "Z");
                        hash_step(c); bump(); scan = SCAN_ID;
                    end else begin
                        push_token(KIND_BAD_CHAR, 0, 0, 10'd1); err = 1;
                    end
                end
            end
            SCAN_NUM: begin
                if (is_num(c)) begin
                    d = {56'd0, c - 8'h30};
                    if (accum > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) ovf = 1;
                    else accum = accum * 64'd10 + d;
                    bump();
                end else begin
                    if (!term) begin
                        push_token(KIND_BAD_NUM, 0, 0, count); err = 1;
                    end else if (ovf) begin
                        push_token(KIND_OVF, 0, 0, count); err = 1;
                    end else begin
                        push_token(KIND_INT, accum, 0, count); scan = SCAN_IDLE;
                    end
                    if (semi) begin
                        push_token(KIND_END, 0, 0, 0); scan = SCAN_IDLE; err = 0;
                    end
                end
            end
            SCAN_ID: begin
                if (c == CH_DASH || c == CH_DOT) ver_seen = 1;
                if (c >= "A" && c <= "Z") upper_seen = 1;
                if (c == CH_DASH || c == CH_DOT || c == CH_UNDER || is_letter(c)
                    || is_num(c)) begin
                    hash_step(c); bump();
                end else begin
                    if (!term) begin
                        push_token(KIND_BAD_ID, 0, 0, count); err = 1;
                    end else if (upper_seen && ver_seen) begin
                        push_token(KIND_UPPER_V, 0, 0, count); err = 1;
                    end else begin
                        push_token(ver_seen ? KIND_VER : KIND_ID, 0, hash_key(hash),
                                   count);
                        scan = SCAN_IDLE;
                    end
                    if (semi) begin
                        push_token(KIND_END, 0, 0, 0); scan = SCAN_IDLE; err = 0;
                    end
                end
            end
            default: begin
                if (semi) begin
                    push_token(KIND_END, 0, 0, 0); scan = SCAN_IDLE;
                end
            end
        endcase
        if (err) scan = SCAN_DROP;
        if (token_q.size() > n) token_q[token_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        token_t t;
        if (!aresetn) begin
            mult_r = HASH_MULT_RST;
            div_r  = HASH_DIV_RST;
            scan   = SCAN_IDLE;
            restart();
            token_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HASH_MULT) mult_r = cfg_data;
                else div_r = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token kind %0d", $time, m_token_kind);
                    fail_count <= fail_count + 1;
                end else begin
                    t = token_q.pop_front();
                    if (t != {m_token_kind, m_int_value, m_key_hash, m_token_len,
                              m_last_of_run}) begin
                        $display("%0t: token mismatch expected kind %0d val %0d key %0h len %0d last %0b, got kind %0d val %0d key %0h len %0d last %0b",
                                 $time, t.kind, t.value, t.key, t.len, t.last,
                                 m_token_kind, m_int_value, m_key_hash, m_token_len,
                                 m_last_of_run);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) lex_char(s_char_in);
        end
    end

endmodule

/* dv/command_token_lexer_test.sv */
// ----------------------------------------------------------------------------
// command_token_lexer_test: stimulus and verdict for the command token lexer
// Drives directed and random command text under varying back-pressure and
// hash settings; the checker beside the block compares every token.
// ----------------------------------------------------------------------------
module command_token_lexer_test;
    import ctl_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [63:0] m_int_value;
    logic [11:0] m_key_hash;
    logic [9:0]  m_token_len;
    logic        m_last_of_run;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_HASH_MULT;
    logic [15:0] cfg_data = 16'd0;
    int          fail_count;
    int          tokens_pending;

    // Idle odds in percent, and a long receiver hold-off.
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_cycles = 0;
    byte         text_q[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    command_token_lexer dut (.*);

    command_token_lexer_check checker_u (.*);

    // Receiver: random stalls, plus a counted hold-off when requested.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Push one word; gaps fall before the offer, never while valid is up.
    task automatic send_char(byte c);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_char(text_q.pop_front());
        s_valid <= 1'b0;
    endtask

    task automatic add_str(string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endtask

    // Wait for every token, then let an unproductive character settle.
    task automatic drain();
        while (tokens_pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic byte pick_char(int cls);
        case (cls)
            0: return byte'($urandom_range(9) + 48);
            1: return byte'($urandom_range(25) + 65);
            2: return byte'($urandom_range(25) + 97);
            3: begin
                case ($urandom_range(2))
                    0: return CH_DASH;
                    1: return CH_DOT;
                    default: return CH_UNDER;
                endcase
            end
            default: return byte'($urandom_range(255));
        endcase
    endfunction

    function automatic byte pick_term();
        case ($urandom_range(4))
            0: return CH_TAB;
            1: return CH_LF;
            2, 3: return CH_SEMI;
            default: return CH_SPACE;
        endcase
    endfunction

    // One mostly well-formed token: number, identifier, version id or noise.
    task automatic add_random_token();
        int len, kind;
        kind = $urandom_range(9);
        len  = $urandom_range(6) + 1;
        if ($urandom_range(40) == 0) len = $urandom_range(25) + 15;
        case (kind)
            0, 1, 2: begin
                for (int i = 0; i < len; i++) text_q.push_back(pick_char(0));
            end
            3, 4, 5: begin
                text_q.push_back(pick_char($urandom_range(1) + 1));
                for (int i = 1; i < len; i++)
                    text_q.push_back(pick_char($urandom_range(2)));
            end
            6, 7: begin
                text_q.push_back(pick_char(2));
                for (int i = 1; i < len; i++)
                    text_q.push_back(pick_char($urandom_range(3) == 0 ? 3 : 2));
            end
            default: begin
                for (int i = 0; i < len; i++) text_q.push_back(pick_char(4));
            end
        endcase
        if ($urandom_range(9) == 0) text_q.push_back(pick_char(4));
        text_q.push_back(pick_term());
    endtask

    task automatic random_phase(int n_tokens);
        for (int i = 0; i < n_tokens; i++) begin
            add_random_token();
            send_text();
        end
        text_q.push_back(CH_SEMI);
        send_text();
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: blanks, end, integers incl. 2^64-1 and overflow, ids,
        // version ids, upper case in a version id, bad chars, dropping.
        add_str(" \t\n;18446744073709551615 18446744073709551616;");
        add_str("abc_Z9 v1.2-x ");
        text_q.push_back(8'hFF);
        add_str("Ab.c;12x34;ab+ q;");
        send_text();
        drain();

        // Extremes of both registers, zero divisor included.
        write_reg(CFG_HASH_MULT, 16'hFFFF);
        write_reg(CFG_HASH_DIV, 16'd0);
        add_str("zz;Q- ;");
        send_text();
        drain();
        write_reg(CFG_HASH_MULT, 16'd0);
        write_reg(CFG_HASH_DIV, 16'hFFFF);
        add_str("a.b;");
        text_q.push_back(8'h80);
        text_q.push_back(8'h7F);
        text_q.push_back(CH_SEMI);
        send_text();
        drain();

        // Sender idles lightly, receiver heavily.
        send_idle = 12; recv_idle = 59;
        write_reg(CFG_HASH_MULT, 16'(($urandom_range(65535))));
        write_reg(CFG_HASH_DIV, 16'($urandom_range(65534) + 1));
        random_phase(60);

        // Long receiver hold-off with the sender still offering.
        hold_cycles = 600;
        random_phase(20);

        // The other way round.
        send_idle = 59; recv_idle = 12;
        write_reg(CFG_HASH_MULT, HASH_MULT_RST);
        write_reg(CFG_HASH_DIV, 16'd1);
        random_phase(60);

        // Neither side idles.
        send_idle = 0; recv_idle = 0;
        write_reg(CFG_HASH_MULT, 16'($urandom_range(65535)));
        write_reg(CFG_HASH_DIV, 16'($urandom_range(65535)));
        random_phase(40);

        drain();
        if (fail_count == 0) begin
            $display("command_token_lexer_test: PASS");
        end else begin
            $display("command_token_lexer_test: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("command_token_lexer_test: FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_hash_step.sv
hw/rtl/command_token_lexer.sv
dv/command_token_lexer_check.sv
dv/command_token_lexer_test.sv
